// ===== hdl/pram_pkg.sv =====
// Shared types and constants for the pixel rotation address mapper.
// Holds field widths, register indexes, mode codes and the geometry bundle.
// No dependencies.
package pram_pkg;

	// Default parameter values
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_FRAC_BITS  = 14;

	// Port field widths
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int SRC_X_W     = 10;
	localparam int SRC_Y_W     = 10;
	localparam int PIX_W       = 24;
	localparam int ADDR_OUT_W  = 26;

	// Register widths
	localparam int DIM_W  = 11;
	localparam int CH_W   = 3;
	localparam int MODE_W = 3;
	localparam int TRIG_W = 16;

	// Derived geometry widths: canvas is four times each side
	localparam int CANVAS_SHIFT = 2;
	localparam int FW_W   = DIM_W + CANVAS_SHIFT;
	localparam int AREA_W = 2 * FW_W + 1;
	localparam int LIM_W  = AREA_W + 3;
	localparam int SPAN_W = 2 * DIM_W + 1;
	localparam int OFF_W  = SPAN_W + 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_MODE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COS_Q      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIN_Q      = 3'd5;

	// Reset values
	localparam logic [DIM_W-1:0]  RST_SRC_WIDTH  = 11'd1024;
	localparam logic [DIM_W-1:0]  RST_SRC_HEIGHT = 11'd1024;
	localparam logic [CH_W-1:0]   RST_CHANNELS   = 3'd3;
	localparam logic [TRIG_W-1:0] RST_COS_Q      = 16'h4000;
	localparam logic [TRIG_W-1:0] RST_SIN_Q      = 16'h0000;

	// Rotation modes; anything from MODE_ARB upward is the arbitrary angle
	localparam logic [MODE_W-1:0] MODE_R0   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_R90  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_R180 = 3'd2;
	localparam logic [MODE_W-1:0] MODE_R270 = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ARB  = 3'd4;

	// Channel count from which the stride is four bytes
	localparam logic [CH_W-1:0] CH_FOUR = 3'd4;

	// Geometry derived from the registers, handed to the datapath
	typedef struct packed {
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic              ch4;
		logic              arb;
		logic [MODE_W-1:0] mode;
		logic [TRIG_W-1:0] cos_q;
		logic [TRIG_W-1:0] sin_q;
		logic [FW_W-1:0]   fw;
		logic [OFF_W-1:0]  offset;
		logic [LIM_W-1:0]  lim_m2;
	} pram_geom_t;

endpackage

// ===== hdl/pixel_rotation_address_mapper_core.sv =====
// Pixel rotation address mapper: maps a source pixel to its destination byte
// address in a rotated frame. Depends on pram_pkg, pram_cfg and pram_pipe.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request per pixel: src_x,
//   src_y and pixel_bytes. Output channel (out_valid/out_ready) returns
//   dest_address and dest_bytes. A pixel outside the source frame or whose
//   address leaves the destination frame gives no result.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   the geometry registers; cfg_ready is always high. Write only while no
//   request is in flight; derived geometry is registered after a write.
//   An accepted request passes stages s1 to s6 and the output register.
//   Throughput: one request per cycle unless the output stalls, set by the
//   seven-stage pipeline with one multiply or one wide add per stage.
//   Stall: when out_ready is low the held result stays; earlier stages keep
//   filling empty slots, so in_ready drops only once every stage is full.
//   Reset (arst_n low) empties the pipeline and restores the register
//   defaults: 1024 by 1024, three channels, no rotation.
module pixel_rotation_address_mapper_core import pram_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SRC_X_W-1:0]    src_x,
	input  logic [SRC_Y_W-1:0]    src_y,
	input  logic [PIX_W-1:0]      pixel_bytes,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ADDR_OUT_W-1:0] dest_address,
	output logic [PIX_W-1:0]      dest_bytes
);

	pram_geom_t geom;

	pram_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	pram_pipe #(
		.FRAC_BITS (FRAC_BITS)
	) u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.src_x        (src_x),
		.src_y        (src_y),
		.pixel_bytes  (pixel_bytes),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dest_address (dest_address),
		.dest_bytes   (dest_bytes),
		.geom         (geom)
	);

endmodule

// ===== hdl/pram_cfg.sv =====
// Register file and derived frame geometry of the rotation address mapper.
// Depends on pram_pkg. Derived values are registered after a write.
module pram_cfg import pram_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output pram_geom_t            geom
);

	logic [DIM_W-1:0]  src_width_q;
	logic [DIM_W-1:0]  src_height_q;
	logic [CH_W-1:0]   channels_q;
	logic [MODE_W-1:0] rot_mode_q;
	logic [TRIG_W-1:0] cos_q_q;
	logic [TRIG_W-1:0] sin_q_q;

	logic [DIM_W-1:0]  w;
	logic [DIM_W-1:0]  h;
	logic              ch4;
	logic              arb;
	logic [FW_W-1:0]   fw_d;
	logic [FW_W-1:0]   fh_d;

	logic [FW_W-1:0]   fw_q;
	logic [FW_W-1:0]   fh_q;
	logic [AREA_W-1:0] area_q;
	logic [LIM_W-1:0]  area_ch_q;
	logic [LIM_W-1:0]  lim_m2_q;
	logic [SPAN_W-1:0] span_q;
	logic [OFF_W-1:0]  offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RST_SRC_WIDTH;
			src_height_q <= RST_SRC_HEIGHT;
			channels_q   <= RST_CHANNELS;
			rot_mode_q   <= MODE_R0;
			cos_q_q      <= RST_COS_Q;
			sin_q_q      <= RST_SIN_Q;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[DIM_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[DIM_W-1:0];
				REG_CHANNELS:   channels_q   <= cfg_data[CH_W-1:0];
				REG_ROT_MODE:   rot_mode_q   <= cfg_data[MODE_W-1:0];
				REG_COS_Q:      cos_q_q      <= cfg_data[TRIG_W-1:0];
				REG_SIN_Q:      sin_q_q      <= cfg_data[TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the frame to the supported maximum
	always_comb begin
		w = src_width_q;
		h = src_height_q;
		if (int'(src_width_q) > MAX_WIDTH) begin
			w = DIM_W'(MAX_WIDTH);
		end
		if (int'(src_height_q) > MAX_HEIGHT) begin
			h = DIM_W'(MAX_HEIGHT);
		end
	end

	assign ch4 = (channels_q >= CH_FOUR);
	assign arb = (rot_mode_q >= MODE_ARB);

	always_comb begin
		if (arb) begin
			fw_d = {w, {CANVAS_SHIFT{1'b0}}};
			fh_d = {h, {CANVAS_SHIFT{1'b0}}};
		end else if (rot_mode_q == MODE_R90 || rot_mode_q == MODE_R270) begin
			fw_d = FW_W'(h);
			fh_d = FW_W'(w);
		end else begin
			fw_d = FW_W'(w);
			fh_d = FW_W'(h);
		end
	end

	// Frame size and canvas offset, one multiply or add per cycle
	always_ff @(posedge clk) begin
		fw_q      <= fw_d;
		fh_q      <= fh_d;
		area_q    <= AREA_W'(fw_q) * AREA_W'(fh_q);
		area_ch_q <= ch4 ? (LIM_W'(area_q) << 2)
		                 : (LIM_W'(area_q) + (LIM_W'(area_q) << 1));
		lim_m2_q  <= area_ch_q - LIM_W'(2);
		span_q    <= SPAN_W'(w) * SPAN_W'({h, 1'b1});
		if (arb) begin
			offset_q <= ch4 ? (OFF_W'(span_q) << 3)
			                : ((OFF_W'(span_q) << 2) + (OFF_W'(span_q) << 1));
		end else begin
			offset_q <= '0;
		end
	end

	always_comb begin
		geom        = '0;
		geom.w      = w;
		geom.h      = h;
		geom.ch4    = ch4;
		geom.arb    = arb;
		geom.mode   = rot_mode_q;
		geom.cos_q  = cos_q_q;
		geom.sin_q  = sin_q_q;
		geom.fw     = fw_q;
		geom.offset = offset_q;
		geom.lim_m2 = lim_m2_q;
	end

endmodule

// ===== hdl/pram_pipe.sv =====
// Seven-stage address pipeline of the rotation address mapper.
// Depends on pram_pkg; geometry comes from pram_cfg.
module pram_pipe import pram_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SRC_X_W-1:0]    src_x,
	input  logic [SRC_Y_W-1:0]    src_y,
	input  logic [PIX_W-1:0]      pixel_bytes,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ADDR_OUT_W-1:0] dest_address,
	output logic [PIX_W-1:0]      dest_bytes,
	input  pram_geom_t            geom
);

	localparam int PROD_W  = SRC_X_W + TRIG_W + 1;
	localparam int SUM_W   = PROD_W + 1;
	localparam int QUOT_W  = SUM_W - FRAC_BITS + 1;
	localparam int COORD_W = (QUOT_W > DIM_W + 1) ? QUOT_W : DIM_W + 1;
	localparam int NYFW_W  = COORD_W + FW_W + 1;
	localparam int LIN_W   = NYFW_W + 1;
	localparam int ADDR_W  = (LIN_W + 3 > LIM_W + 1) ? LIN_W + 3 : LIM_W + 1;
	localparam logic [SUM_W-1:0] RND = SUM_W'((64'd1 << FRAC_BITS) - 64'd1);

	// Stage enables and valid bits
	logic en1, en2, en3, en4, en5, en6, en7;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	logic out_valid_q;

	// Stage 1 inputs
	logic [DIM_W-1:0]         xw, yw, nx_ex, ny_ex;
	logic                     in_range;
	logic signed [SRC_X_W:0]  xs;
	logic signed [SRC_Y_W:0]  ys;

	// Payload registers
	logic [PIX_W-1:0]         bytes_s1, bytes_s2, bytes_s3, bytes_s4, bytes_s5, bytes_s6;
	logic [DIM_W-1:0]         nx_ex_s1, ny_ex_s1, nx_ex_s2, ny_ex_s2;
	logic signed [PROD_W-1:0] pxc_s1, pys_s1, pxs_s1, pyc_s1;
	logic signed [SUM_W-1:0]  nxs_s2, nys_s2;
	logic signed [SUM_W-1:0]  nx_adj, ny_adj, nx_quo, ny_quo;
	logic signed [COORD_W-1:0] nx_s3, ny_s3, nx_s4;
	logic signed [NYFW_W-1:0] nyfw_s4;
	logic signed [LIN_W-1:0]  lin_s5;
	logic signed [ADDR_W-1:0] lin_ext, lin_scaled, addr_s6;
	logic                     keep;
	logic [ADDR_OUT_W-1:0]    dest_address_q;
	logic [PIX_W-1:0]         dest_bytes_q;

	// A stage advances when it is empty or the next one advances
	assign en7      = !out_valid_q || out_ready;
	assign en6      = !v6_s6 || en7;
	assign en5      = !v5_s5 || en6;
	assign en4      = !v4_s4 || en5;
	assign en3      = !v3_s3 || en4;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign in_ready = en1;

	assign xw       = DIM_W'(src_x);
	assign yw       = DIM_W'(src_y);
	assign in_range = (xw < geom.w) && (yw < geom.h);
	assign xs       = $signed({1'b0, src_x});
	assign ys       = $signed({1'b0, src_y});

	always_comb begin
		unique case (geom.mode)
			MODE_R0: begin
				nx_ex = xw;
				ny_ex = yw;
			end
			MODE_R90: begin
				nx_ex = geom.h - DIM_W'(1) - yw;
				ny_ex = xw;
			end
			MODE_R180: begin
				nx_ex = geom.w - DIM_W'(1) - xw;
				ny_ex = geom.h - DIM_W'(1) - yw;
			end
			MODE_R270: begin
				nx_ex = yw;
				ny_ex = geom.w - DIM_W'(1) - xw;
			end
			default: begin
				nx_ex = xw;
				ny_ex = yw;
			end
		endcase
	end

	// Truncate toward zero: bias negative sums before the arithmetic shift
	assign nx_adj = nxs_s2 + (nxs_s2[SUM_W-1] ? RND : '0);
	assign ny_adj = nys_s2 + (nys_s2[SUM_W-1] ? RND : '0);
	assign nx_quo = nx_adj >>> FRAC_BITS;
	assign ny_quo = ny_adj >>> FRAC_BITS;

	assign lin_ext    = ADDR_W'(lin_s5);
	assign lin_scaled = geom.ch4 ? (lin_ext <<< 2) : (lin_ext + (lin_ext <<< 1));

	// Drop negative addresses and those whose last byte leaves the frame
	assign keep = !addr_s6[ADDR_W-1] && (addr_s6 < ADDR_W'($signed(geom.lim_m2)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			v4_s4       <= 1'b0;
			v5_s5       <= 1'b0;
			v6_s6       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) v1_s1 <= in_valid && in_range;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) v5_s5 <= v4_s4;
			if (en6) v6_s6 <= v5_s5;
			if (en7) out_valid_q <= v6_s6 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			bytes_s1 <= pixel_bytes;
			nx_ex_s1 <= nx_ex;
			ny_ex_s1 <= ny_ex;
			pxc_s1   <= PROD_W'(xs) * PROD_W'($signed(geom.cos_q));
			pys_s1   <= PROD_W'(ys) * PROD_W'($signed(geom.sin_q));
			pxs_s1   <= PROD_W'(xs) * PROD_W'($signed(geom.sin_q));
			pyc_s1   <= PROD_W'(ys) * PROD_W'($signed(geom.cos_q));
		end
		if (en2) begin
			bytes_s2 <= bytes_s1;
			nx_ex_s2 <= nx_ex_s1;
			ny_ex_s2 <= ny_ex_s1;
			nxs_s2   <= SUM_W'(pxc_s1) - SUM_W'(pys_s1);
			nys_s2   <= SUM_W'(pxs_s1) + SUM_W'(pyc_s1);
		end
		if (en3) begin
			bytes_s3 <= bytes_s2;
			nx_s3    <= geom.arb ? nx_quo[COORD_W-1:0] : COORD_W'(nx_ex_s2);
			ny_s3    <= geom.arb ? ny_quo[COORD_W-1:0] : COORD_W'(ny_ex_s2);
		end
		if (en4) begin
			bytes_s4 <= bytes_s3;
			nx_s4    <= nx_s3;
			nyfw_s4  <= NYFW_W'(ny_s3) * NYFW_W'($signed({1'b0, geom.fw}));
		end
		if (en5) begin
			bytes_s5 <= bytes_s4;
			lin_s5   <= LIN_W'(nyfw_s4) + LIN_W'(nx_s4);
		end
		if (en6) begin
			bytes_s6 <= bytes_s5;
			addr_s6  <= ADDR_W'($signed({1'b0, geom.offset})) + lin_scaled;
		end
		if (en7) begin
			dest_address_q <= addr_s6[ADDR_OUT_W-1:0];
			dest_bytes_q   <= bytes_s6;
		end
	end

	assign out_valid    = out_valid_q;
	assign dest_address = dest_address_q;
	assign dest_bytes   = dest_bytes_q;

endmodule

// ===== hdl/pram_checker.sv =====
// Port-level checks for the pixel rotation address mapper.
// Depends on pram_pkg; bound to pixel_rotation_address_mapper_core below.
module pram_checker import pram_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  cfg_ready,
	input logic [ADDR_OUT_W-1:0] dest_address,
	input logic [PIX_W-1:0]      dest_bytes
);

	// Hold a stalled result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dest_address) && $stable(dest_bytes))
		else $error("stalled result changed or vanished");

	// Back-pressure on the input only comes from a stalled output
	a_in_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input refused while output free");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port refused a write");

	// No result straight out of reset
	a_rst_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result shown right after reset");

endmodule

bind pixel_rotation_address_mapper_core pram_checker u_pram_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for pixel_rotation_address_mapper_core.
// Maps each pixel with its own model of the rotation, checks every result in order.
// Depends on pram_pkg and the core RTL only.
module tb_top import pram_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_PIXELS = 1800;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 20;
	localparam int SETTLE_WAIT = 12;
	localparam int PRINT_CAP   = 200;

	typedef struct {
		logic [SRC_X_W-1:0] x;
		logic [SRC_Y_W-1:0] y;
		logic [PIX_W-1:0]   pix;
	} pixel_req_t;

	typedef struct {
		logic [ADDR_OUT_W-1:0] addr;
		logic [PIX_W-1:0]      pix;
	} mapped_pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SRC_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [SRC_X_W-1:0]    src_x = '0;
	logic [SRC_Y_W-1:0]    src_y = '0;
	logic [PIX_W-1:0]      pixel_bytes = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [ADDR_OUT_W-1:0] dest_address;
	logic [PIX_W-1:0]      dest_bytes;

	// Local copy of the geometry registers
	logic [DIM_W-1:0]  geo_w    = RST_SRC_WIDTH;
	logic [DIM_W-1:0]  geo_h    = RST_SRC_HEIGHT;
	logic [CH_W-1:0]   geo_ch   = RST_CHANNELS;
	logic [MODE_W-1:0] geo_mode = MODE_R0;
	logic [TRIG_W-1:0] geo_cos  = RST_COS_Q;
	logic [TRIG_W-1:0] geo_sin  = RST_SIN_Q;

	pixel_req_t    pending_q[$];
	mapped_pixel_t mapped_q[$];

	int send_gap_pct   = 0;
	int sink_stall_pct = 0;
	int errors         = 0;
	int pixels_taken   = 0;
	int pixels_dropped = 0;
	int results_seen   = 0;
	int cfg_writes     = 0;
	int setups         = 0;
	int arb_setups     = 0;
	int quiet_cycles   = 0;

	pixel_rotation_address_mapper_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.src_x        (src_x),
		.src_y        (src_y),
		.pixel_bytes  (pixel_bytes),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dest_address (dest_address),
		.dest_bytes   (dest_bytes)
	);

	always #5 clk = ~clk;

	// Divide by 2^FRAC_BITS, truncating toward zero
	function automatic longint frac_trunc(input longint n);
		if (n < 0) return -((-n) >>> DEF_FRAC_BITS);
		return n >>> DEF_FRAC_BITS;
	endfunction

	// Destination address of one pixel under the current geometry; 0 when dropped
	function automatic bit map_pixel(input logic [SRC_X_W-1:0] px,
			input logic [SRC_Y_W-1:0] py, output logic [ADDR_OUT_W-1:0] addr);
		longint x, y, w, h, ch, fw, fh, nx, ny, c, s, offset, a;
		x = longint'(px);
		y = longint'(py);
		w = (geo_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : longint'(geo_w);
		h = (geo_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : longint'(geo_h);
		ch = longint'(geo_ch);
		if (ch < 3) ch = 3;
		if (ch > 4) ch = 4;
		offset = 0;
		addr = '0;
		if (x >= w || y >= h) return 1'b0;
		case (geo_mode)
			MODE_R0: begin
				fw = w; fh = h; nx = x; ny = y;
			end
			MODE_R90: begin
				fw = h; fh = w; nx = h - 1 - y; ny = x;
			end
			MODE_R180: begin
				fw = w; fh = h; nx = w - 1 - x; ny = h - 1 - y;
			end
			MODE_R270: begin
				fw = h; fh = w; nx = y; ny = w - 1 - x;
			end
			default: begin
				c = longint'($signed(geo_cos));
				s = longint'($signed(geo_sin));
				fw = w << CANVAS_SHIFT;
				fh = h << CANVAS_SHIFT;
				nx = frac_trunc(x * c - y * s);
				ny = frac_trunc(x * s + y * c);
				offset = ch * (fw / 2) * (fh / 2) + ch * (fw / 2);
			end
		endcase
		a = offset + (ny * fw + nx) * ch;
		if (a < 0 || a + 2 >= fw * fh * ch) return 1'b0;
		addr = a[ADDR_OUT_W-1:0];
		return 1'b1;
	endfunction

	always @(posedge clk) begin : pixel_driver
		pixel_req_t nxt;
		logic [ADDR_OUT_W-1:0] want_addr;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				pixels_taken++;
				if (map_pixel(src_x, src_y, want_addr))
					mapped_q.push_back('{want_addr, pixel_bytes});
				else
					pixels_dropped++;
			end
			// hold the request until it is taken
			if (!in_valid || in_ready) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					nxt = pending_q.pop_front();
					in_valid    <= 1'b1;
					src_x       <= nxt.x;
					src_y       <= nxt.y;
					pixel_bytes <= nxt.pix;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		mapped_pixel_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (mapped_q.size() == 0) begin
					errors++;
					if (errors <= PRINT_CAP)
						$display("%0t ns: result with none expected: addr %h bytes %h",
							$time, dest_address, dest_bytes);
				end else begin
					want = mapped_q.pop_front();
					if (dest_address !== want.addr) begin
						errors++;
						if (errors <= PRINT_CAP)
							$display("%0t ns: dest_address expected %h actual %h",
								$time, want.addr, dest_address);
					end
					if (dest_bytes !== want.pix) begin
						errors++;
						if (errors <= PRINT_CAP)
							$display("%0t ns: dest_bytes expected %h actual %h",
								$time, want.pix, dest_bytes);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
		case (idx)
			REG_SRC_WIDTH:  geo_w    = val[DIM_W-1:0];
			REG_SRC_HEIGHT: geo_h    = val[DIM_W-1:0];
			REG_CHANNELS:   geo_ch   = val[CH_W-1:0];
			REG_ROT_MODE:   geo_mode = val[MODE_W-1:0];
			REG_COS_Q:      geo_cos  = val;
			REG_SIN_Q:      geo_sin  = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_q.size() != 0 || in_valid || mapped_q.size() != 0) @(posedge clk);
	endtask

	// Drain, let dropped pixels leave the pipe, then rewrite the geometry
	task automatic apply_setup(input logic [CFG_DATA_W-1:0] w, h, ch, mode, c, s);
		wait_idle();
		repeat (SETTLE_WAIT) @(posedge clk);
		write_reg(REG_SRC_WIDTH, w);
		write_reg(REG_SRC_HEIGHT, h);
		write_reg(REG_CHANNELS, ch);
		write_reg(REG_ROT_MODE, mode);
		write_reg(REG_COS_Q, c);
		write_reg(REG_SIN_Q, s);
		setups++;
		if (mode[MODE_W-1:0] >= MODE_ARB) arb_setups++;
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic queue_pixel(input int x, y, input logic [PIX_W-1:0] pix);
		pending_q.push_back('{SRC_X_W'(x), SRC_Y_W'(y), pix});
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_dim();
		int pick;
		logic [CFG_DATA_W-1:0] d;
		pick = $urandom_range(99);
		if (pick < 50) d = CFG_DATA_W'($urandom_range(1, 1024));
		else if (pick < 70) d = CFG_DATA_W'($urandom_range(1, 16));
		else if (pick < 82) d = 16'd1024;
		else if (pick < 86) d = '0;
		else d = CFG_DATA_W'($urandom_range(1025, 2047));
		// junk above the register width must be ignored
		if ($urandom_range(4) == 0) d[CFG_DATA_W-1:DIM_W] = (CFG_DATA_W-DIM_W)'($urandom);
		return d;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_trig();
		int pick;
		pick = $urandom_range(99);
		if (pick < 65) return CFG_DATA_W'($urandom_range(32768) - 16384);
		if (pick < 80) begin
			case ($urandom_range(2))
				0: return 16'sd16384;
				1: return -16'sd16384;
				default: return '0;
			endcase
		end
		return CFG_DATA_W'($urandom);
	endfunction

	task automatic random_setup();
		logic [CFG_DATA_W-1:0] mode, ch;
		mode = CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(4));
		ch = CFG_DATA_W'($urandom_range(7));
		if ($urandom_range(4) == 0) ch[CFG_DATA_W-1:CH_W] = (CFG_DATA_W-CH_W)'($urandom);
		if ($urandom_range(4) == 0) mode[CFG_DATA_W-1:MODE_W] = (CFG_DATA_W-MODE_W)'($urandom);
		apply_setup(pick_dim(), pick_dim(), ch, mode, pick_trig(), pick_trig());
	endtask

	// Mostly pixels inside the source frame, some anywhere in the field range
	task automatic queue_random(input int n);
		int wl, hl, x, y;
		wl = (geo_w == 0) ? 1 : ((geo_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(geo_w));
		hl = (geo_h == 0) ? 1 : ((geo_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(geo_h));
		repeat (n) begin
			x = int'(($urandom_range(3) != 0) ? $urandom_range(wl - 1) : $urandom_range(1023));
			y = int'(($urandom_range(3) != 0) ? $urandom_range(hl - 1) : $urandom_range(1023));
			queue_pixel(x, y, PIX_W'($urandom));
		end
	endtask

	initial begin : sequencer
		int grp, sent, n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		send_gap_pct   = 25;
		sink_stall_pct = 78;

		// reset geometry: plain copy into 1024 by 1024, three bytes a pixel
		queue_pixel(0, 0, 24'h000000);
		queue_pixel(1023, 1023, 24'hFFFFFF);
		queue_pixel(1023, 0, 24'hA5A5A5);
		queue_pixel(0, 1023, 24'h5A5A5A);
		// quarter turn, four byte stride
		apply_setup(1024, 1024, 4, MODE_R90, 0, 0);
		queue_pixel(0, 0, 24'h010203);
		queue_pixel(1023, 1023, 24'hFFFFFF);
		queue_pixel(512, 7, 24'h0F0F0F);
		// half turn on a tiny frame, channel count below three, pixels outside
		apply_setup(5, 3, 0, MODE_R180, 0, 0);
		queue_pixel(0, 0, 24'h112233);
		queue_pixel(4, 2, 24'h445566);
		queue_pixel(5, 0, 24'h778899);
		queue_pixel(0, 3, 24'hAABBCC);
		// three quarter turn, oversized frame clamped, channel count above four
		apply_setup(2047, 1500, 7, MODE_R270, 0, 0);
		queue_pixel(1023, 1023, 24'hFEDCBA);
		queue_pixel(0, 0, 24'h123456);
		queue_pixel(1000, 3, 24'h654321);
		// arbitrary 90 degrees on a flat frame: most pixels leave the canvas
		apply_setup(16, 2, 3, MODE_ARB, 0, 16'sd16384);
		queue_pixel(0, 0, 24'hC0FFEE);
		queue_pixel(15, 1, 24'hBADBAD);
		queue_pixel(3, 1, 24'h0BAD00);
		// unknown mode code with trig at the ends of its range
		apply_setup(8, 8, 4, 3'd6, 16'h8000, 16'h7FFF);
		queue_pixel(7, 7, 24'h800001);
		queue_pixel(0, 0, 24'h7FFFFE);
		queue_pixel(7, 0, 24'h333333);
		// zero width: nothing maps
		apply_setup(0, 8, 3, MODE_R0, 0, 0);
		queue_pixel(0, 0, 24'h999999);
		queue_pixel(0, 5, 24'h424242);

		for (grp = 0; grp < 3; grp++) begin
			case (grp)
				0: begin send_gap_pct = 25; sink_stall_pct = 78; end
				1: begin send_gap_pct = 78; sink_stall_pct = 25; end
				default: begin send_gap_pct = 0; sink_stall_pct = 0; end
			endcase
			sent = 0;
			while (sent < RAND_PIXELS / 3) begin
				random_setup();
				n = $urandom_range(20, 80);
				queue_random(n);
				sent += n;
			end
		end

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Covered %0d pixels over %0d geometry setups (%0d arbitrary angle), %0d writes.",
			pixels_taken, setups, arb_setups, cfg_writes);
		$display("Checked %0d mapped results; %0d pixels fell outside their frame.",
			results_seen, pixels_dropped);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/pram_pkg.sv
hdl/pram_cfg.sv
hdl/pram_pipe.sv
hdl/pixel_rotation_address_mapper_core.sv
hdl/pram_checker.sv
bench/tb_top.sv
